[sv/mnva_pkg.sv]
// ----------------------------------------------------------------------------
// mnva_pkg
// shared types and constants of the midi note voice allocator
// ----------------------------------------------------------------------------
`default_nettype none

package mnva_pkg;

  // status byte of a note-on message
  localparam logic [7:0] NOTE_ON_STATUS = 8'h90;

  // slot index width, covers up to 64 voice slots
  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    ACT_IGNORED  = 2'd0,
    ACT_ASSIGNED = 2'd1,
    ACT_FREED    = 2'd2,
    ACT_DROPPED  = 2'd3
  } action_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [6:0]       pitch;
    logic             held_found;
    logic [IDX_W-1:0] held_idx;
    logic             empty_found;
    logic [IDX_W-1:0] empty_idx;
  } token_t;

  // slot write broadcast to all cells
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [6:0]       pitch;
    logic [6:0]       velocity;
  } commit_t;

endpackage

`default_nettype wire

[sv/mnva_cell.sv]
// ----------------------------------------------------------------------------
// mnva_cell
// one voice slot: holds pitch and velocity, updates the passing search token
// ----------------------------------------------------------------------------
`default_nettype none

module mnva_cell import mnva_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    slot_en,
  input  wire token_t  tok_in,
  input  wire commit_t commit,
  output token_t       tok_out
);

  logic [6:0] pitch_r;
  logic [6:0] vel_r;
  token_t     tok_r;
  token_t     tok_nxt;
  logic       occupied;
  logic       match;

  assign occupied = (vel_r != 7'd0);
  assign match    = slot_en && occupied && (pitch_r == tok_in.pitch);

  always_comb begin
    tok_nxt = tok_in;
    // keep the lowest index found so far
    if (match && !tok_in.held_found) begin
      tok_nxt.held_found = 1'b1;
      tok_nxt.held_idx   = IDX_W'(CELL_IDX);
    end
    if (slot_en && !occupied && !tok_in.empty_found) begin
      tok_nxt.empty_found = 1'b1;
      tok_nxt.empty_idx   = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= 7'd0;
      vel_r   <= 7'd0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (commit.we && (commit.idx == IDX_W'(CELL_IDX))) begin
        pitch_r <= commit.pitch;
        vel_r   <= commit.velocity;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

[sv/midi_note_voice_allocator.sv]
// ----------------------------------------------------------------------------
// midi_note_voice_allocator
// polyphonic voice slot allocation for midi note-on and release messages
// ----------------------------------------------------------------------------
// Each input item is one midi message. A search token walks a row of
// MAX_VOICES slot cells, one cell per cycle, collecting the lowest occupied
// slot that holds the pitch and the lowest empty slot among the first
// active_voices slots. When the token leaves the last cell the controller
// decides the action, broadcasts one slot write and loads the result
// register. It is loaded once the token has passed every cell, the finished
// token has been registered and the result register is free. The next item
// is taken the cycle after the result is loaded, even while that result
// still waits on out_ready, so no new item is taken before the last one's
// result is loaded. The wait grows while an earlier result still sits
// unaccepted in the result register. active_voices is to be written through
// cfg_we only while idle; the block itself does not enforce it. Values above
// MAX_VOICES act as MAX_VOICES.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_voice_allocator import mnva_pkg::*; #(
  parameter int MAX_VOICES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_active_voices,
  // input items
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_status_byte,
  input  wire logic [6:0] in_note_number,
  input  wire logic [6:0] in_note_velocity,
  // result items
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_action,
  output logic [3:0]      out_slot,
  output logic [6:0]      out_pitch_out,
  output logic [6:0]      out_velocity_out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] active_r;

  // message held while its token is in the row
  logic       note_on_r, note_on_nxt;
  logic [6:0] nvel_r, nvel_nxt;

  token_t     tok0_r, tok0_nxt;
  token_t     res_r, res_nxt;
  commit_t    commit_r, commit_nxt;

  logic       out_valid_r, out_valid_nxt;
  action_t    out_action_r, out_action_nxt;
  logic [3:0] out_slot_r, out_slot_nxt;
  logic [6:0] out_pitch_r, out_pitch_nxt;
  logic [6:0] out_vel_r, out_vel_nxt;

  // token chain, chain[0] enters the first cell
  token_t                chain [0:MAX_VOICES];
  logic [MAX_VOICES-1:0] slot_en;

  // decision on the finished token
  action_t    dec_action;
  logic [IDX_W-1:0] dec_idx;
  logic [6:0] dec_vel;
  commit_t    dec_commit;

  assign chain[0] = tok0_r;

  genvar g;
  generate
    for (g = 0; g < MAX_VOICES; g++) begin : g_cell
      // slots at or above the voice count are neither searched nor assigned
      assign slot_en[g] = ({27'd0, active_r} > 32'(g));

      mnva_cell #(
        .CELL_IDX (g)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .slot_en (slot_en[g]),
        .tok_in  (chain[g]),
        .commit  (commit_r),
        .tok_out (chain[g+1])
      );
    end
  endgenerate

  // action from what the token found
  always_comb begin
    dec_action = ACT_IGNORED;
    dec_idx    = '0;
    dec_vel    = 7'd0;
    dec_commit = '0;
    if (note_on_r) begin
      if (!res_r.held_found && (nvel_r != 7'd0)) begin
        if (res_r.empty_found) begin
          // new note into the lowest empty slot
          dec_action          = ACT_ASSIGNED;
          dec_idx             = res_r.empty_idx;
          dec_vel             = nvel_r;
          dec_commit.we       = 1'b1;
          dec_commit.idx      = res_r.empty_idx;
          dec_commit.pitch    = res_r.pitch;
          dec_commit.velocity = nvel_r;
        end else begin
          dec_action = ACT_DROPPED;
        end
      end else if (res_r.held_found && (nvel_r == 7'd0)) begin
        // release frees the lowest slot holding the pitch
        dec_action          = ACT_FREED;
        dec_idx             = res_r.held_idx;
        dec_commit.we       = 1'b1;
        dec_commit.idx      = res_r.held_idx;
        dec_commit.pitch    = 7'd0;
        dec_commit.velocity = 7'd0;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    note_on_nxt    = note_on_r;
    nvel_nxt       = nvel_r;
    tok0_nxt       = tok0_r;
    tok0_nxt.valid = 1'b0;
    res_nxt        = res_r;
    commit_nxt     = '0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_action_nxt = out_action_r;
    out_slot_nxt   = out_slot_r;
    out_pitch_nxt  = out_pitch_r;
    out_vel_nxt    = out_vel_r;
    in_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          tok0_nxt.valid       = 1'b1;
          tok0_nxt.pitch       = in_note_number;
          tok0_nxt.held_found  = 1'b0;
          tok0_nxt.held_idx    = '0;
          tok0_nxt.empty_found = 1'b0;
          tok0_nxt.empty_idx   = '0;
          note_on_nxt          = (in_status_byte == NOTE_ON_STATUS);
          nvel_nxt             = in_note_velocity;
          state_nxt            = S_SCAN;
        end
      end
      S_SCAN: begin
        // token leaves the last cell
        if (chain[MAX_VOICES].valid) begin
          res_nxt   = chain[MAX_VOICES];
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // result register free: deliver and write the slot
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = dec_action;
          out_slot_nxt   = dec_idx[3:0];
          out_pitch_nxt  = res_r.pitch;
          out_vel_nxt    = dec_vel;
          commit_nxt     = dec_commit;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 5'd10;
      tok0_r      <= '0;
      commit_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok0_r      <= tok0_nxt;
      commit_r    <= commit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        active_r <= cfg_active_voices;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    note_on_r    <= note_on_nxt;
    nvel_r       <= nvel_nxt;
    res_r        <= res_nxt;
    out_action_r <= out_action_nxt;
    out_slot_r   <= out_slot_nxt;
    out_pitch_r  <= out_pitch_nxt;
    out_vel_r    <= out_vel_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_slot         = out_slot_r;
  assign out_pitch_out    = out_pitch_r;
  assign out_velocity_out = out_vel_r;

endmodule

`default_nettype wire

[sv/mnva_checker.sv]
// ----------------------------------------------------------------------------
// mnva_checker
// port level checks of the voice allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mnva_checker import mnva_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_action,
  input wire logic [3:0] out_slot,
  input wire logic [6:0] out_velocity_out
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_slot))
    else $error("result changed while stalled");

  // ignored and dropped items carry no slot and no velocity
  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_IGNORED || out_action == ACT_DROPPED)
      |-> out_slot == 4'd0 && out_velocity_out == 7'd0)
    else $error("slot or velocity on an ignored or dropped item");

  // a freed slot reports zero velocity
  a_freed_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_FREED |-> out_velocity_out == 7'd0)
    else $error("nonzero velocity on a freed slot");

  // an assigned slot always holds a sounding velocity
  a_assigned_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_ASSIGNED |-> out_velocity_out != 7'd0)
    else $error("slot assigned with zero velocity");

  // no item is taken in the cycle after one was taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in the slot row");

endmodule

bind midi_note_voice_allocator mnva_checker u_mnva_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_action       (out_action),
  .out_slot         (out_slot),
  .out_velocity_out (out_velocity_out)
);

`default_nettype wire

[verif/midi_note_voice_allocator_tb.sv]
// ----------------------------------------------------------------------------
// midi_note_voice_allocator_tb
// self-checking bench for the midi voice slot allocator
// ----------------------------------------------------------------------------
// Drives midi messages through the valid/ready input channel and checks each
// result item against an in-bench copy of the voice slot table. A short table
// of directed messages runs first at the reset voice count. After it come
// random phases, each at a voice count written while the block is idle.
// Most random items are note-ons and releases drawn from a narrow pitch
// window, so that held notes, full tables and releases occur often.
// The rest are stray status bytes and full-range fields. Both channels idle
// in random bursts, except in the last phase.
// ----------------------------------------------------------------------------

module midi_note_voice_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mnva_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES  = 10;

  // one result item as the block reports it
  typedef struct {
    action_t    act;
    logic [3:0] slot;
    logic [6:0] pitch;
    logic [6:0] vel;
  } voice_result_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct {
    logic [7:0]    status;
    logic [6:0]    pitch;
    logic [6:0]    vel;
    bit            typed;
    voice_result_t want;
  } msg_row_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports, all inputs known from time zero
  logic       cfg_we            = 1'b0;
  logic [4:0] cfg_active_voices = 5'd10;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic [7:0] in_status_byte    = 8'h00;
  logic [6:0] in_note_number    = 7'd0;
  logic [6:0] in_note_velocity  = 7'd0;
  logic       out_valid;
  logic       out_ready         = 1'b1;
  logic [1:0] out_action;
  logic [3:0] out_slot;
  logic [6:0] out_pitch_out;
  logic [6:0] out_velocity_out;

  midi_note_voice_allocator #(
    .MAX_VOICES(NUM_SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_active_voices(cfg_active_voices),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_status_byte   (in_status_byte),
    .in_note_number   (in_note_number),
    .in_note_velocity (in_note_velocity),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_slot         (out_slot),
    .out_pitch_out    (out_pitch_out),
    .out_velocity_out (out_velocity_out)
  );

  // bench copy of the slot table and the voice count register
  logic [6:0] held_pitch    [NUM_SLOTS];
  logic [6:0] held_velocity [NUM_SLOTS];
  logic [4:0] voice_limit = 5'd10;

  voice_result_t voice_results_due[$];
  msg_row_t      directed_rows[$];

  // expectation riding along with the message on the input port
  bit            cur_typed = 1'b0;
  voice_result_t cur_want;

  bit         idle_on    = 1'b1;
  logic [6:0] pitch_base = 7'd60;
  int         err_count  = 0;
  int         quiet_cycles = 0;

  // one mismatch line, counted
  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // advance the slot table by one message and return the result it yields
  function automatic voice_result_t allocate_voice(logic [7:0] status, logic [6:0] pitch,
                                                   logic [6:0] vel);
    voice_result_t r;
    int n;
    int held_idx;
    int free_idx;
    int i;
    r = '{act: ACT_IGNORED, slot: 4'd0, pitch: pitch, vel: 7'd0};
    // counts above the slot row saturate
    n = (voice_limit > NUM_SLOTS) ? NUM_SLOTS : int'(voice_limit);
    held_idx = -1;
    free_idx = -1;
    if (status == NOTE_ON_STATUS) begin
      // walk downward so the lowest matching index wins
      for (i = n - 1; i >= 0; i--) begin
        if (held_velocity[i] != 7'd0 && held_pitch[i] == pitch) held_idx = i;
        if (held_velocity[i] == 7'd0) free_idx = i;
      end
      if (held_idx < 0 && vel != 7'd0) begin
        if (free_idx >= 0) begin
          held_pitch[free_idx]    = pitch;
          held_velocity[free_idx] = vel;
          r.act  = ACT_ASSIGNED;
          r.slot = 4'(free_idx);
          r.vel  = vel;
        end else begin
          r.act = ACT_DROPPED;
        end
      end else if (held_idx >= 0 && vel == 7'd0) begin
        held_pitch[held_idx]    = 7'd0;
        held_velocity[held_idx] = 7'd0;
        r.act  = ACT_FREED;
        r.slot = 4'(held_idx);
      end
    end
    return r;
  endfunction

  function automatic void add_row(logic [7:0] status, logic [6:0] pitch, logic [6:0] vel,
                                  bit typed = 1'b0, action_t act = ACT_IGNORED,
                                  logic [3:0] slot = 4'd0, logic [6:0] want_vel = 7'd0);
    msg_row_t row;
    row.status = status;
    row.pitch  = pitch;
    row.vel    = vel;
    row.typed  = typed;
    row.want   = '{act: act, slot: slot, pitch: pitch, vel: want_vel};
    directed_rows.push_back(row);
  endfunction

  // present one message at the falling edge and hold it until taken
  task automatic send_msg(logic [7:0] status, logic [6:0] pitch, logic [6:0] vel,
                          bit typed, voice_result_t want);
    // an idle burst may come before any item
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_status_byte   = status;
    in_note_number   = pitch;
    in_note_velocity = vel;
    cur_typed        = typed;
    cur_want         = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // mostly well-formed note traffic in a narrow pitch window, some noise
  task automatic send_random_msg();
    logic [7:0] status;
    logic [6:0] pitch;
    logic [6:0] vel;
    int pick;
    pick   = $urandom_range(0, 99);
    status = NOTE_ON_STATUS;
    pitch  = pitch_base + 7'($urandom_range(0, 19));
    vel    = 7'd0;
    if (pick < 55) begin
      // note-on, may hit a held pitch or a full table
      vel = 7'($urandom_range(1, 127));
    end else if (pick < 85) begin
      // release, often of a held pitch
      vel = 7'd0;
    end else if (pick < 92) begin
      // anything at all
      status = 8'($urandom_range(0, 255));
      pitch  = 7'($urandom_range(0, 127));
      vel    = 7'($urandom_range(0, 127));
    end else begin
      // near misses: note-offs, other channels, other status classes
      status = {4'($urandom_range(8, 15)), 4'($urandom_range(0, 15))};
      vel    = 7'($urandom_range(0, 127));
    end
    send_msg(status, pitch, vel, 1'b0, cur_want);
  endtask

  // pause the sender until every expected result has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (voice_results_due.size() != 0) @(negedge clk);
  endtask

  // voice count write, only while nothing is in flight
  task automatic write_voice_count(logic [4:0] count);
    cfg_we            = 1'b1;
    cfg_active_voices = count;
    @(negedge clk);
    cfg_we      = 1'b0;
    voice_limit = count;
  endtask

  // predict on every taken item, check every delivered result
  always @(posedge clk) begin
    voice_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = allocate_voice(in_status_byte, in_note_number, in_note_velocity);
        // typed rows keep the table advancing but check against the typed value
        if (cur_typed) want = cur_want;
        voice_results_due.push_back(want);
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (voice_results_due.size() == 0) begin
          report_mismatch("result with nothing pending, action", out_action, -1);
        end else begin
          want = voice_results_due.pop_front();
          if (out_action !== want.act) report_mismatch("action", out_action, want.act);
          if (out_slot !== want.slot) report_mismatch("slot", out_slot, want.slot);
          if (out_pitch_out !== want.pitch) report_mismatch("pitch", out_pitch_out, want.pitch);
          if (out_velocity_out !== want.vel) report_mismatch("velocity", out_velocity_out, want.vel);
        end
      end
    end
  end

  // receiver stalls in bursts while idling is allowed
  always begin
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
      out_ready = 1'b1;
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("midi_note_voice_allocator_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int i;
    int p;
    logic [4:0] count;
    for (i = 0; i < NUM_SLOTS; i++) begin
      held_pitch[i]    = 7'd0;
      held_velocity[i] = 7'd0;
    end

    // directed messages at the reset voice count of ten
    // note-off status is ignored even with a velocity
    add_row(8'h80, 7'd60, 7'd100, 1'b1, ACT_IGNORED, 4'd0, 7'd0);
    // extremes of pitch and velocity into an empty table
    add_row(NOTE_ON_STATUS, 7'd0, 7'd127, 1'b1, ACT_ASSIGNED, 4'd0, 7'd127);
    add_row(NOTE_ON_STATUS, 7'd127, 7'd1, 1'b1, ACT_ASSIGNED, 4'd1, 7'd1);
    // note-on for a held pitch is ignored
    add_row(NOTE_ON_STATUS, 7'd0, 7'd50);
    // release of a held pitch
    add_row(NOTE_ON_STATUS, 7'd0, 7'd0);
    // release of a pitch nobody holds
    add_row(NOTE_ON_STATUS, 7'd5, 7'd0);
    // other status bytes: all bits high, all bits low and a note-on on another channel
    add_row(8'hff, 7'd127, 7'd127, 1'b1, ACT_IGNORED, 4'd0, 7'd0);
    add_row(8'h00, 7'd0, 7'd0, 1'b1, ACT_IGNORED, 4'd0, 7'd0);
    add_row(8'h91, 7'd64, 7'd64, 1'b1, ACT_IGNORED, 4'd0, 7'd0);
    // fill the remaining nine slots, the tenth note-on is dropped
    for (p = 0; p < 10; p++) add_row(NOTE_ON_STATUS, 7'(16 + p), 7'(p * 13 + 1));
    // free the slot holding the top pitch, then release it again
    add_row(NOTE_ON_STATUS, 7'd127, 7'd0);
    add_row(NOTE_ON_STATUS, 7'd127, 7'd0);
    // the freed slot is reused before higher ones
    add_row(NOTE_ON_STATUS, 7'd85, 7'd42);
    add_row(NOTE_ON_STATUS, 7'd32, 7'd0);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k])
      send_msg(directed_rows[k].status, directed_rows[k].pitch, directed_rows[k].vel,
               directed_rows[k].typed, directed_rows[k].want);

    // random phases; held notes carry over each voice count change, so slots
    // beyond a lowered count keep their contents and may return later
    for (i = 0; i < NUM_PHASES; i++) begin
      wait_drained();
      case (i)
        0: count = 5'd16;
        1: count = 5'd1;
        2: count = 5'd0;
        3: count = 5'd31;
        4: count = 5'd5;
        5: count = 5'd17;
        6: count = 5'd2;
        NUM_PHASES - 1: count = 5'd16;
        default: count = 5'($urandom_range(0, 31));
      endcase
      write_voice_count(count);
      pitch_base = 7'($urandom_range(0, 108));
      // the last phase runs without any idling
      if (i == NUM_PHASES - 1) idle_on = 1'b0;
      repeat (PHASE_ITEMS) send_random_msg();
    end

    // drain, then give the cell row time to show any stray result
    wait_drained();
    repeat (NUM_SLOTS + 8) @(negedge clk);
    if (voice_results_due.size() != 0)
      report_mismatch("results still pending", 0, voice_results_due.size());
    if (err_count == 0) begin
      $display("midi_note_voice_allocator_tb: done, clean");
    end else begin
      $display("midi_note_voice_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule
